// ===== design/lci_pkg.sv =====
// shared types and constants for the line / circle intersection pipeline
// no dependencies; used by the cell modules and the top level
`default_nettype none

package lci_pkg;

  // one numerator per output coordinate
  localparam int LANES = 4;

  typedef enum logic [1:0] {
    HIT_NONE    = 2'd0,
    HIT_TANGENT = 2'd1,
    HIT_TWO     = 2'd2,
    HIT_DEGEN   = 2'd3
  } hit_t;

  // per-stage pipeline control handed along the cell rows
  typedef struct packed {
    logic adv;
    logic vld;
  } step_t;

endpackage

`default_nettype wire

// ===== design/lci_mul.sv =====
// two-stage unsigned multiplier built from four half-width partial products
// no dependencies
`default_nettype none

module lci_mul #(
  parameter int AW = 8,
  parameter int BW = 8
) (
  input  logic           clk,
  input  logic           adv,
  input  logic [AW-1:0]  a,
  input  logic [BW-1:0]  b,
  output logic [AW+BW-1:0] p
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] ll_nxt, ll_r;
  logic [AL+BH-1:0] lh_nxt, lh_r;
  logic [AH+BL-1:0] hl_nxt, hl_r;
  logic [AH+BH-1:0] hh_nxt, hh_r;
  logic [PW-1:0]    p_nxt, p_r;

  always_comb begin
    ll_nxt = (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
    lh_nxt = (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
    hl_nxt = (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
    hh_nxt = (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
    p_nxt  = PW'(ll_r) + (PW'(lh_r) << BL) + (PW'(hl_r) << AL) + (PW'(hh_r) << (AL + BL));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ll_r <= ll_nxt;
      lh_r <= lh_nxt;
      hl_r <= hl_nxt;
      hh_r <= hh_nxt;
      p_r  <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

// ===== design/lci_sqrt_cell.sv =====
// one cell of the square root row: settles one root bit per item
// depends on lci_pkg
`default_nettype none

module lci_sqrt_cell #(
  parameter int SW = 8,
  parameter int K  = 0,
  parameter int PW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lci_pkg::step_t   step_i,
  input  logic [2*SW-1:0]  rem_i,
  input  logic [SW-1:0]    root_i,
  input  logic [PW-1:0]    pay_i,
  output logic             vld_o,
  output logic [2*SW-1:0]  rem_o,
  output logic [SW-1:0]    root_o,
  output logic [PW-1:0]    pay_o
);

  localparam int NB = 2 * SW + 1;

  logic [NB-1:0]     trial;
  logic              take;
  logic [2*SW-1:0]   rem_nxt, rem_r;
  logic [SW-1:0]     root_nxt, root_r;
  logic [PW-1:0]     pay_r;
  logic              vld_r;

  // (root + 2^k)^2 - root^2, root has no bits at or below k yet
  always_comb begin
    trial    = (NB'(root_i) << (K + 1)) | (NB'(1) << (2 * K));
    take     = NB'(rem_i) >= trial;
    rem_nxt  = take ? rem_i - trial[2*SW-1:0] : rem_i;
    root_nxt = take ? (root_i | (SW'(1) << K)) : root_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (step_i.adv) begin
      vld_r <= step_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (step_i.adv) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      pay_r  <= pay_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign pay_o  = pay_r;

endmodule

`default_nettype wire

// ===== design/lci_div_cell.sv =====
// one cell of the divider row: one quotient bit for each of the four lanes
// depends on lci_pkg
`default_nettype none

module lci_div_cell #(
  parameter int NW = 16,
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int K  = 0,
  parameter int PW = 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lci_pkg::step_t                       step_i,
  input  logic [DW-1:0]                        den_i,
  input  logic [lci_pkg::LANES-1:0][NW-1:0]    rem_i,
  input  logic [lci_pkg::LANES-1:0][QW-1:0]    q_i,
  input  logic [PW-1:0]                        pay_i,
  output logic                                 vld_o,
  output logic [DW-1:0]                        den_o,
  output logic [lci_pkg::LANES-1:0][NW-1:0]    rem_o,
  output logic [lci_pkg::LANES-1:0][QW-1:0]    q_o,
  output logic [PW-1:0]                        pay_o
);

  logic [NW-1:0]                             dsh;
  logic [lci_pkg::LANES-1:0][NW-1:0]         rem_nxt, rem_r;
  logic [lci_pkg::LANES-1:0][QW-1:0]         q_nxt, q_r;
  logic [DW-1:0]                             den_r;
  logic [PW-1:0]                             pay_r;
  logic                                      vld_r;

  assign dsh = NW'(den_i) << K;

  always_comb begin
    for (int l = 0; l < lci_pkg::LANES; l++) begin
      if (rem_i[l] >= dsh) begin
        rem_nxt[l] = rem_i[l] - dsh;
        q_nxt[l]   = q_i[l] | (QW'(1) << K);
      end else begin
        rem_nxt[l] = rem_i[l];
        q_nxt[l]   = q_i[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (step_i.adv) begin
      vld_r <= step_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (step_i.adv) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      den_r <= den_i;
      pay_r <= pay_i;
    end
  end

  assign vld_o = vld_r;
  assign den_o = den_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;
  assign pay_o = pay_r;

endmodule

`default_nettype wire

// ===== design/lci_out_buf.sv =====
// two-entry output buffer: result register plus skid entry
// no dependencies
`default_nettype none

module lci_out_buf #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [DW-1:0] in_data,
  output logic          ready_o,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [DW-1:0] out_data
);

  logic          m_v_nxt, m_v_r, s_v_nxt, s_v_r;
  logic [DW-1:0] m_d_nxt, m_d_r, s_d_nxt, s_d_r;

  always_comb begin
    m_v_nxt = m_v_r;
    s_v_nxt = s_v_r;
    m_d_nxt = m_d_r;
    s_d_nxt = s_d_r;
    if (m_v_r && out_tready) begin
      if (s_v_r) begin
        m_d_nxt = s_d_r;
        s_v_nxt = 1'b0;
      end else if (in_vld) begin
        m_d_nxt = in_data;
      end else begin
        m_v_nxt = 1'b0;
      end
    end else if (in_vld) begin
      if (!m_v_r) begin
        m_v_nxt = 1'b1;
        m_d_nxt = in_data;
      end else begin
        s_v_nxt = 1'b1;
        s_d_nxt = in_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      s_v_r <= 1'b0;
    end else begin
      m_v_r <= m_v_nxt;
      s_v_r <= s_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_d_r <= m_d_nxt;
    s_d_r <= s_d_nxt;
  end

  assign ready_o    = !s_v_r;
  assign out_tvalid = m_v_r;
  assign out_data   = m_d_r;

endmodule

`default_nettype wire

// ===== design/line_circle_intersection_top.sv =====
// line / circle intersection pipeline, top level
// depends on lci_pkg, lci_mul, lci_sqrt_cell, lci_div_cell, lci_out_buf

// Takes one query per cycle while in_tready is high and returns one result per
// query, in order. A front of split multipliers forms the exact discriminant,
// a row of 2*COORD_WIDTH square root cells settles one root bit each, and a
// row of COORD_WIDTH divider cells settles one quotient bit for all four
// coordinates at once. The whole row moves together; a two-entry output buffer
// keeps the input open while a result waits, and in_tready drops only when both
// entries hold.
`default_nettype none

module line_circle_intersection_top #(
  parameter int COORD_WIDTH = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // line_start_x, line_start_y, line_end_x, line_end_y, centre_x, centre_y, circle_radius
  input  logic [((7*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // first_x, first_y, second_x, second_y
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0] out_tdata,
  // hit_status
  output logic [1:0] out_tuser
);

  localparam int W      = COORD_WIDTH;
  localparam int OUT_TW = ((4 * W + 7) / 8) * 8;
  localparam int DFW    = W + 1;
  localparam int DMW    = W + 1;
  localparam int P1W    = 2 * DMW;
  localparam int DR2W   = P1W + 1;
  localparam int DSW    = P1W + 2;
  localparam int DMG    = DSW - 1;
  localparam int R2W    = 2 * W;
  localparam int RDW    = R2W + DR2W;
  localparam int DDW    = 2 * DMG;
  localparam int DCW    = DDW + 1;
  localparam int DPW    = DMG + DMW;
  localparam int SW     = 2 * W;
  localparam int NSQ    = 2 * SW;
  localparam int VW     = DMW + SW;
  localparam int NW     = 3 * W + 4;
  localparam int LN     = lci_pkg::LANES;
  localparam int S2W    = 2 * DFW + 2 * W + 2;
  localparam int S5W    = 1 + 2 * DFW + DR2W + 2 * W;
  localparam int SPW    = 2 + 2 * NW + 2 * DFW + DR2W + 2 * W;
  localparam int DPAY   = 2 + 2 * LN + 2 * W;
  localparam int BUFW   = 4 * W + 2;

  logic adv;

  // input fields and differences
  logic [W-1:0]   f_sx, f_sy, f_ex, f_ey, f_cx, f_cy, f_r;
  logic [DFW-1:0] dx_nxt, dy_nxt, px_nxt, py_nxt, qx_nxt, qy_nxt;

  assign f_sx = in_tdata[0*W +: W];
  assign f_sy = in_tdata[1*W +: W];
  assign f_ex = in_tdata[2*W +: W];
  assign f_ey = in_tdata[3*W +: W];
  assign f_cx = in_tdata[4*W +: W];
  assign f_cy = in_tdata[5*W +: W];
  assign f_r  = in_tdata[6*W +: W];

  always_comb begin
    dx_nxt = DFW'($signed(f_ex)) - DFW'($signed(f_sx));
    dy_nxt = DFW'($signed(f_ey)) - DFW'($signed(f_sy));
    px_nxt = DFW'($signed(f_sx)) - DFW'($signed(f_cx));
    py_nxt = DFW'($signed(f_sy)) - DFW'($signed(f_cy));
    qx_nxt = DFW'($signed(f_ex)) - DFW'($signed(f_cx));
    qy_nxt = DFW'($signed(f_ey)) - DFW'($signed(f_cy));
  end

  logic           s1_v_r;
  logic [DFW-1:0] s1_dx_r, s1_dy_r, s1_px_r, s1_py_r, s1_qx_r, s1_qy_r;
  logic [W-1:0]   s1_cx_r, s1_cy_r, s1_r_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx_r <= dx_nxt;
      s1_dy_r <= dy_nxt;
      s1_px_r <= px_nxt;
      s1_py_r <= py_nxt;
      s1_qx_r <= qx_nxt;
      s1_qy_r <= qy_nxt;
      s1_cx_r <= f_cx;
      s1_cy_r <= f_cy;
      s1_r_r  <= f_r;
    end
  end

  // first products: dx^2, dy^2, px*qy, qx*py, r^2 on magnitudes
  logic [DMW-1:0] m_dx, m_dy, m_px, m_py, m_qx, m_qy;
  logic [W-1:0]   m_r;
  logic [P1W-1:0] p_dx2, p_dy2, p_pq, p_qp;
  logic [R2W-1:0] p_rr;

  always_comb begin
    m_dx = s1_dx_r[DFW-1] ? -s1_dx_r : s1_dx_r;
    m_dy = s1_dy_r[DFW-1] ? -s1_dy_r : s1_dy_r;
    m_px = s1_px_r[DFW-1] ? -s1_px_r : s1_px_r;
    m_py = s1_py_r[DFW-1] ? -s1_py_r : s1_py_r;
    m_qx = s1_qx_r[DFW-1] ? -s1_qx_r : s1_qx_r;
    m_qy = s1_qy_r[DFW-1] ? -s1_qy_r : s1_qy_r;
    m_r  = s1_r_r[W-1] ? -s1_r_r : s1_r_r;
  end

  lci_mul #(.AW(DMW), .BW(DMW)) u_mul_dx2 (.clk(clk), .adv(adv), .a(m_dx), .b(m_dx), .p(p_dx2));
  lci_mul #(.AW(DMW), .BW(DMW)) u_mul_dy2 (.clk(clk), .adv(adv), .a(m_dy), .b(m_dy), .p(p_dy2));
  lci_mul #(.AW(DMW), .BW(DMW)) u_mul_pq (.clk(clk), .adv(adv), .a(m_px), .b(m_qy), .p(p_pq));
  lci_mul #(.AW(DMW), .BW(DMW)) u_mul_qp (.clk(clk), .adv(adv), .a(m_qx), .b(m_py), .p(p_qp));
  lci_mul #(.AW(W), .BW(W)) u_mul_rr (.clk(clk), .adv(adv), .a(m_r), .b(m_r), .p(p_rr));

  logic           s2_v_r, s3_v_r;
  logic [S2W-1:0] s2_side_r, s3_side_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_side_r <= {s1_dx_r, s1_dy_r, s1_cx_r, s1_cy_r,
                    s1_px_r[DFW-1] ^ s1_qy_r[DFW-1], s1_qx_r[DFW-1] ^ s1_py_r[DFW-1]};
      s3_side_r <= s2_side_r;
    end
  end

  // dr2 and the cross product D
  logic [DFW-1:0]  t3_dx, t3_dy;
  logic [W-1:0]    t3_cx, t3_cy;
  logic            t3_spq, t3_sqp;
  logic [DSW-1:0]  ta, tb, d_nxt;
  logic [DR2W-1:0] dr2_nxt;

  assign {t3_dx, t3_dy, t3_cx, t3_cy, t3_spq, t3_sqp} = s3_side_r;

  always_comb begin
    dr2_nxt = DR2W'(p_dx2) + DR2W'(p_dy2);
    ta      = t3_spq ? -DSW'(p_pq) : DSW'(p_pq);
    tb      = t3_sqp ? -DSW'(p_qp) : DSW'(p_qp);
    d_nxt   = ta - tb;
  end

  logic            s4_v_r;
  logic [DR2W-1:0] s4_dr2_r;
  logic [DSW-1:0]  s4_d_r;
  logic [R2W-1:0]  s4_rr2_r;
  logic [DFW-1:0]  s4_dx_r, s4_dy_r;
  logic [W-1:0]    s4_cx_r, s4_cy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_dr2_r <= dr2_nxt;
      s4_d_r   <= d_nxt;
      s4_rr2_r <= p_rr;
      s4_dx_r  <= t3_dx;
      s4_dy_r  <= t3_dy;
      s4_cx_r  <= t3_cx;
      s4_cy_r  <= t3_cy;
    end
  end

  // second products: r^2*dr2, D^2, D*dy, D*dx
  logic [DMG-1:0] m_d;
  logic [DMW-1:0] m_dx4, m_dy4;
  logic [RDW-1:0] p_rd;
  logic [DDW-1:0] p_dd;
  logic [DPW-1:0] p_ddy, p_ddx;

  always_comb begin
    m_d   = DMG'(s4_d_r[DSW-1] ? -s4_d_r : s4_d_r);
    m_dx4 = s4_dx_r[DFW-1] ? -s4_dx_r : s4_dx_r;
    m_dy4 = s4_dy_r[DFW-1] ? -s4_dy_r : s4_dy_r;
  end

  lci_mul #(.AW(R2W), .BW(DR2W)) u_mul_rd (.clk(clk), .adv(adv), .a(s4_rr2_r), .b(s4_dr2_r),
                                           .p(p_rd));
  lci_mul #(.AW(DMG), .BW(DMG)) u_mul_dd (.clk(clk), .adv(adv), .a(m_d), .b(m_d), .p(p_dd));
  lci_mul #(.AW(DMG), .BW(DMW)) u_mul_ddy (.clk(clk), .adv(adv), .a(m_d), .b(m_dy4), .p(p_ddy));
  lci_mul #(.AW(DMG), .BW(DMW)) u_mul_ddx (.clk(clk), .adv(adv), .a(m_d), .b(m_dx4), .p(p_ddx));

  logic           s5_v_r, s6_v_r;
  logic [S5W-1:0] s5_side_r, s6_side_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_side_r <= {s4_d_r[DSW-1], s4_dx_r, s4_dy_r, s4_dr2_r, s4_cx_r, s4_cy_r};
      s6_side_r <= s5_side_r;
    end
  end

  // discriminant and status
  logic            t6_dneg;
  logic [DFW-1:0]  t6_dx, t6_dy;
  logic [DR2W-1:0] t6_dr2;
  logic [W-1:0]    t6_cx, t6_cy;
  logic [DCW-1:0]  disc;
  logic [1:0]      st_nxt;
  logic [NW-1:0]   ddy_nxt, ndx_nxt;

  assign {t6_dneg, t6_dx, t6_dy, t6_dr2, t6_cx, t6_cy} = s6_side_r;

  always_comb begin
    disc = DCW'(p_rd) - DCW'(p_dd);
    if (t6_dr2 == '0) begin
      st_nxt = lci_pkg::HIT_DEGEN;
    end else if (disc[DCW-1]) begin
      st_nxt = lci_pkg::HIT_NONE;
    end else if (disc == '0) begin
      st_nxt = lci_pkg::HIT_TANGENT;
    end else begin
      st_nxt = lci_pkg::HIT_TWO;
    end
    ddy_nxt = (t6_dneg ^ t6_dy[DFW-1]) ? -NW'(p_ddy) : NW'(p_ddy);
    // -D*dx
    ndx_nxt = (t6_dneg ^ t6_dx[DFW-1]) ? NW'(p_ddx) : -NW'(p_ddx);
  end

  logic           s7_v_r;
  logic [NSQ-1:0] s7_n_r;
  logic [SPW-1:0] s7_pay_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_n_r   <= disc[NSQ-1:0];
      s7_pay_r <= {st_nxt, ddy_nxt, ndx_nxt, t6_dx, t6_dy, t6_dr2, t6_cx, t6_cy};
    end
  end

  // square root row
  logic [NSQ-1:0] sq_rem  [SW+1];
  logic [SW-1:0]  sq_root [SW+1];
  logic [SPW-1:0] sq_pay  [SW+1];
  logic           sq_vld  [SW+1];

  assign sq_rem[0]  = s7_n_r;
  assign sq_root[0] = '0;
  assign sq_pay[0]  = s7_pay_r;
  assign sq_vld[0]  = s7_v_r;

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    lci_sqrt_cell #(.SW(SW), .K(SW - 1 - i), .PW(SPW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .step_i (lci_pkg::step_t'{adv: adv, vld: sq_vld[i]}),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .pay_i  (sq_pay[i]),
      .vld_o  (sq_vld[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .pay_o  (sq_pay[i+1])
    );
  end

  // root times |dx| and |dy|
  logic [1:0]      u_st;
  logic [NW-1:0]   u_ddy, u_ndx;
  logic [DFW-1:0]  u_dx, u_dy;
  logic [DR2W-1:0] u_dr2;
  logic [W-1:0]    u_cx, u_cy;
  logic [DMW-1:0]  m_dxs, m_dys;
  logic [VW-1:0]   p_vx, p_vy;

  assign {u_st, u_ddy, u_ndx, u_dx, u_dy, u_dr2, u_cx, u_cy} = sq_pay[SW];
  assign m_dxs = u_dx[DFW-1] ? -u_dx : u_dx;
  assign m_dys = u_dy[DFW-1] ? -u_dy : u_dy;

  lci_mul #(.AW(DMW), .BW(SW)) u_mul_vx (.clk(clk), .adv(adv), .a(m_dxs), .b(sq_root[SW]),
                                         .p(p_vx));
  lci_mul #(.AW(DMW), .BW(SW)) u_mul_vy (.clk(clk), .adv(adv), .a(m_dys), .b(sq_root[SW]),
                                         .p(p_vy));

  logic           s8_v_r, s9_v_r;
  logic [SPW-1:0] s8_pay_r, s9_pay_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_pay_r <= sq_pay[SW];
      s9_pay_r <= s8_pay_r;
    end
  end

  // four numerators: first_x, first_y, second_x, second_y
  logic [1:0]            w_st;
  logic [NW-1:0]         w_ddy, w_ndx, w_vx, w_vy;
  logic [DFW-1:0]        w_dx, w_dy;
  logic [DR2W-1:0]       w_dr2;
  logic [W-1:0]          w_cx, w_cy;
  logic [LN-1:0][NW-1:0] num_nxt;

  assign {w_st, w_ddy, w_ndx, w_dx, w_dy, w_dr2, w_cx, w_cy} = s9_pay_r;

  always_comb begin
    // sign of dy folds into the x term, a horizontal line counts as positive
    w_vx = (w_dx[DFW-1] ^ w_dy[DFW-1]) ? -NW'(p_vx) : NW'(p_vx);
    w_vy = NW'(p_vy);
    num_nxt[0] = w_ddy - w_vx;
    num_nxt[1] = w_ndx - w_vy;
    num_nxt[2] = w_ddy + w_vx;
    num_nxt[3] = w_ndx + w_vy;
  end

  logic                  s10_v_r;
  logic [LN-1:0][NW-1:0] s10_num_r;
  logic [1:0]            s10_st_r;
  logic [DR2W-1:0]       s10_dr2_r;
  logic [W-1:0]          s10_cx_r, s10_cy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_num_r <= num_nxt;
      s10_st_r  <= w_st;
      s10_dr2_r <= w_dr2;
      s10_cx_r  <= w_cx;
      s10_cy_r  <= w_cy;
    end
  end

  logic [LN-1:0][NW-1:0] mag_nxt;
  logic [LN-1:0]         sgn_nxt;

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      sgn_nxt[l] = s10_num_r[l][NW-1];
      mag_nxt[l] = sgn_nxt[l] ? -s10_num_r[l] : s10_num_r[l];
    end
  end

  logic                  s11_v_r;
  logic [LN-1:0][NW-1:0] s11_mag_r;
  logic [LN-1:0]         s11_sgn_r;
  logic [1:0]            s11_st_r;
  logic [DR2W-1:0]       s11_dr2_r;
  logic [W-1:0]          s11_cx_r, s11_cy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_mag_r <= mag_nxt;
      s11_sgn_r <= sgn_nxt;
      s11_st_r  <= s10_st_r;
      s11_dr2_r <= s10_dr2_r;
      s11_cx_r  <= s10_cx_r;
      s11_cy_r  <= s10_cy_r;
    end
  end

  // quotient at or above 2^W saturates any coordinate
  logic [NW-1:0] den_top;
  logic [LN-1:0] big_nxt;

  always_comb begin
    den_top = NW'(s11_dr2_r) << W;
    for (int l = 0; l < LN; l++) begin
      big_nxt[l] = s11_mag_r[l] >= den_top;
    end
  end

  logic                  s12_v_r;
  logic [LN-1:0][NW-1:0] s12_mag_r;
  logic [DR2W-1:0]       s12_dr2_r;
  logic [DPAY-1:0]       s12_pay_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_mag_r <= s11_mag_r;
      s12_dr2_r <= s11_dr2_r;
      s12_pay_r <= {s11_st_r, s11_sgn_r, big_nxt, s11_cx_r, s11_cy_r};
    end
  end

  // divider row
  logic [LN-1:0][NW-1:0] dv_rem [W+1];
  logic [LN-1:0][W-1:0]  dv_q   [W+1];
  logic [DR2W-1:0]       dv_den [W+1];
  logic [DPAY-1:0]       dv_pay [W+1];
  logic                  dv_vld [W+1];

  assign dv_rem[0] = s12_mag_r;
  assign dv_q[0]   = '0;
  assign dv_den[0] = s12_dr2_r;
  assign dv_pay[0] = s12_pay_r;
  assign dv_vld[0] = s12_v_r;

  for (genvar i = 0; i < W; i++) begin : g_div
    lci_div_cell #(.NW(NW), .DW(DR2W), .QW(W), .K(W - 1 - i), .PW(DPAY)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .step_i (lci_pkg::step_t'{adv: adv, vld: dv_vld[i]}),
      .den_i  (dv_den[i]),
      .rem_i  (dv_rem[i]),
      .q_i    (dv_q[i]),
      .pay_i  (dv_pay[i]),
      .vld_o  (dv_vld[i+1]),
      .den_o  (dv_den[i+1]),
      .rem_o  (dv_rem[i+1]),
      .q_o    (dv_q[i+1]),
      .pay_o  (dv_pay[i+1])
    );
  end

  // add to the centre and saturate, or zero the coordinates when there is no hit
  logic [1:0]           z_st;
  logic [LN-1:0]        z_sgn, z_big;
  logic [W-1:0]         z_cx, z_cy;
  logic [W:0]           qv;
  logic [W+1:0]         sum;
  logic [LN-1:0][W-1:0] coord;
  logic                 hit;

  assign {z_st, z_sgn, z_big, z_cx, z_cy} = dv_pay[W];

  always_comb begin
    hit = (z_st == lci_pkg::HIT_TANGENT) || (z_st == lci_pkg::HIT_TWO);
    qv  = '0;
    sum = '0;
    for (int l = 0; l < LN; l++) begin
      qv  = z_big[l] ? ((W+1)'(1) << W) : (W+1)'(dv_q[W][l]);
      sum = (W+2)'($signed(l % 2 == 0 ? z_cx : z_cy));
      sum = z_sgn[l] ? sum - (W+2)'(qv) : sum + (W+2)'(qv);
      if (!sum[W+1] && sum[W:W-1] != 2'b00) begin
        coord[l] = {1'b0, {(W-1){1'b1}}};
      end else if (sum[W+1] && sum[W:W-1] != 2'b11) begin
        coord[l] = {1'b1, {(W-1){1'b0}}};
      end else begin
        coord[l] = sum[W-1:0];
      end
      if (!hit) begin
        coord[l] = '0;
      end
    end
  end

  // valid bits of the stages outside the cell rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      s7_v_r  <= 1'b0;
      s8_v_r  <= 1'b0;
      s9_v_r  <= 1'b0;
      s10_v_r <= 1'b0;
      s11_v_r <= 1'b0;
      s12_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= in_tvalid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      s7_v_r  <= s6_v_r;
      s8_v_r  <= sq_vld[SW];
      s9_v_r  <= s8_v_r;
      s10_v_r <= s9_v_r;
      s11_v_r <= s10_v_r;
      s12_v_r <= s11_v_r;
    end
  end

  logic [BUFW-1:0] buf_out;

  lci_out_buf #(.DW(BUFW)) u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (dv_vld[W] && adv),
    .in_data    ({coord[3], coord[2], coord[1], coord[0], z_st}),
    .ready_o    (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (buf_out)
  );

  assign in_tready = adv;
  assign out_tuser = buf_out[1:0];
  assign out_tdata = OUT_TW'(buf_out[BUFW-1:2]);

endmodule

`default_nettype wire

// ===== sim/line_circle_intersection_top_tb.sv =====
// self-checking testbench for line_circle_intersection_top
// depends on lci_pkg and the design sources; predicts each result in wide integers
`default_nettype none

module line_circle_intersection_top_tb;

  localparam int CW = 24;
  localparam int WDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 120;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [159:0] wide_t;

  typedef struct {
    coord_t sx, sy, ex, ey, cx, cy, rad;
  } query_t;

  typedef struct {
    lci_pkg::hit_t status;
    coord_t        x1, y1, x2, y2;
  } hit_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7*CW-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [4*CW-1:0] out_tdata;
  logic [1:0] out_tuser;

  hit_result_t expected_hits[$];
  bit failed = 0;
  bit quiet = 0;
  bit stall_req = 0;
  int idle_cycles = 0;

  line_circle_intersection_top #(.COORD_WIDTH(CW)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic wide_t int_sqrt(wide_t n);
    wide_t root, cand;
    root = 0;
    for (int i = 63; i >= 0; i--) begin
      cand = root | (wide_t'(1) << i);
      if (cand * cand <= n) root = cand;
    end
    return root;
  endfunction

  // truncating divide, quotient magnitude capped at 2^40, then saturate
  function automatic coord_t place_coord(coord_t c, wide_t num, wide_t dr2);
    wide_t mag, v;
    mag = (num < 0) ? -num : num;
    mag = mag / dr2;
    if (mag > (wide_t'(1) << 40)) mag = wide_t'(1) << 40;
    v = (num < 0) ? wide_t'(c) - mag : wide_t'(c) + mag;
    if (v < -(wide_t'(1) << (CW-1))) v = -(wide_t'(1) << (CW-1));
    if (v > (wide_t'(1) << (CW-1)) - 1) v = (wide_t'(1) << (CW-1)) - 1;
    return coord_t'(v);
  endfunction

  function automatic hit_result_t predict_hits(query_t q);
    hit_result_t r;
    wide_t dx, dy, dr2, dd, rr, disc, root, vx, vy, ddy, ndx;
    r = '{lci_pkg::HIT_NONE, 0, 0, 0, 0};
    dx = wide_t'(q.ex) - wide_t'(q.sx);
    dy = wide_t'(q.ey) - wide_t'(q.sy);
    dr2 = dx * dx + dy * dy;
    if (dr2 == 0) begin
      r.status = lci_pkg::HIT_DEGEN;
      return r;
    end
    dd = (wide_t'(q.sx) - q.cx) * (wide_t'(q.ey) - q.cy)
       - (wide_t'(q.ex) - q.cx) * (wide_t'(q.sy) - q.cy);
    rr = wide_t'(q.rad);
    disc = rr * rr * dr2 - dd * dd;
    if (disc < 0) return r;
    r.status = (disc == 0) ? lci_pkg::HIT_TANGENT : lci_pkg::HIT_TWO;
    root = int_sqrt(disc);
    // sign of dy taken as +1 for a horizontal line
    vx = ((dy < 0) ? -dx : dx) * root;
    vy = ((dy < 0) ? -dy : dy) * root;
    ddy = dd * dy;
    ndx = -(dd * dx);
    r.x1 = place_coord(q.cx, ddy - vx, dr2);
    r.y1 = place_coord(q.cy, ndx - vy, dr2);
    r.x2 = place_coord(q.cx, ddy + vx, dr2);
    r.y2 = place_coord(q.cy, ndx + vy, dr2);
    return r;
  endfunction

  task automatic send_query(query_t q);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tdata <= {q.rad, q.cy, q.cx, q.ey, q.ex, q.sy, q.sx};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_hits.push_back(predict_hits(q));
  endtask

  // stop offering items and wait until every result has come
  task automatic wait_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  function automatic coord_t rand_coord();
    return coord_t'($urandom());
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int span;
    if ($urandom_range(0, 9) < 3) begin
      q = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
            rand_coord(), rand_coord(), rand_coord()};
    end else begin
      // compact scene around the centre so most lines cross the circle
      span = 1 << $urandom_range(4, 20);
      q.cx = rand_coord() >>> $urandom_range(0, 8);
      q.cy = rand_coord() >>> $urandom_range(0, 8);
      q.sx = coord_t'(q.cx + $signed($urandom_range(0, 2*span)) - span);
      q.sy = coord_t'(q.cy + $signed($urandom_range(0, 2*span)) - span);
      q.ex = coord_t'(q.cx + $signed($urandom_range(0, 2*span)) - span);
      q.ey = coord_t'(q.cy + $signed($urandom_range(0, 2*span)) - span);
      if ($urandom_range(0, 7) == 0) q.ey = q.sy;
      if ($urandom_range(0, 15) == 0) q.ex = q.sx;
      if ($urandom_range(0, 20) == 0) begin
        q.ex = q.sx;
        q.ey = q.sy;
      end
      q.rad = coord_t'($signed($urandom_range(0, 2*span)) - span);
    end
    return q;
  endfunction

  task automatic test_directed();
    coord_t mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    send_query('{256, 256, 256, 256, 0, 0, 512});          // coincident points
    send_query('{-512, 1024, 512, 1024, 0, 0, 256});      // miss
    send_query('{-512, 256, 512, 256, 0, 0, 256});        // tangent, horizontal
    send_query('{-512, 0, 512, 0, 0, 0, 256});            // horizontal through centre
    send_query('{0, -512, 0, 512, 0, 0, 256});            // vertical
    send_query('{100, 700, 300, -500, 50, 20, 900});      // negative dy
    send_query('{100, -700, 300, 500, 50, 20, -900});     // negative radius
    send_query('{-300, 0, 300, 0, 0, 0, 0});              // zero radius through centre
    send_query('{mn, mn, mx, mx, 0, 0, mx});              // extreme diagonal
    send_query('{mn, 0, mx, 0, mx, mx, mx});              // saturating results
    send_query('{mn, mn, mn, mx, mx, mn, mn});
    send_query('{mx, mx, mx, mx, mn, mn, mn});
    send_query('{mn, mx, mx, mn, 0, 0, 1});
    send_query('{0, 0, 1, 0, 0, 0, mx});                  // tiny direction, huge radius
    send_query('{-1, -1, 1, 1, -1, 1, 1});
    send_query('{mx, 0, mx, 1, mn, 0, mx});
  endtask

  task automatic test_random(int n);
    repeat (n) send_query(rand_query());
  endtask

  task automatic test_backpressure();
    wait_results();
    stall_req = 1;
    repeat (150) send_query(rand_query());
  endtask

  task automatic test_pause_drain();
    wait_results();
    @(posedge clk);
    test_random(40);
  endtask

  task automatic test_no_idle();
    quiet = 1;
    test_random(100);
  endtask

  // result sink with random stalls and one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (stall_req) begin
        stall_req = 0;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      hit_result_t e;
      if (expected_hits.size() == 0) begin
        $error("unexpected result item: hit_status %0d", out_tuser);
        failed = 1;
      end else begin
        e = expected_hits.pop_front();
        if (out_tuser !== e.status) begin
          $error("hit_status: expected %0d, got %0d", e.status, out_tuser);
          failed = 1;
        end
        if (out_tdata[CW-1:0] !== e.x1) begin
          $error("first_x: expected %0d, got %0d", e.x1, $signed(out_tdata[CW-1:0]));
          failed = 1;
        end
        if (out_tdata[2*CW-1:CW] !== e.y1) begin
          $error("first_y: expected %0d, got %0d", e.y1,
                 $signed(out_tdata[2*CW-1:CW]));
          failed = 1;
        end
        if (out_tdata[3*CW-1:2*CW] !== e.x2) begin
          $error("second_x: expected %0d, got %0d", e.x2,
                 $signed(out_tdata[3*CW-1:2*CW]));
          failed = 1;
        end
        if (out_tdata[4*CW-1:3*CW] !== e.y2) begin
          $error("second_y: expected %0d, got %0d", e.y2,
                 $signed(out_tdata[4*CW-1:3*CW]));
          failed = 1;
        end
      end
    end
  end

  // watchdog: cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(200);
    test_backpressure();
    test_pause_drain();
    test_random(100);
    test_no_idle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && expected_hits.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
